/* hw/rtl/i2p_pkg.sv */
`default_nettype none
// Shared types, codes and helper functions of the infix to prefix converter.
// Used by every module of the block; depends on nothing else.

package i2p_pkg;

    localparam int P_MAX_TOKENS = 64;
    localparam int Q_DEPTH      = 4;
    localparam int QAW          = $clog2(Q_DEPTH);
    localparam int QCW          = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] KIND_NUM   = 3'd0;
    localparam logic [2:0] KIND_FUNC  = 3'd1;
    localparam logic [2:0] KIND_OP    = 3'd2;
    localparam logic [2:0] KIND_LPAR  = 3'd3;
    localparam logic [2:0] KIND_RPAR  = 3'd4;

    localparam logic [2:0] CLS_NUM  = 3'd0;
    localparam logic [2:0] CLS_FUNC = 3'd1;
    localparam logic [2:0] CLS_OP   = 3'd2;
    localparam logic [2:0] CLS_LPAR = 3'd3;
    localparam logic [2:0] CLS_RPAR = 3'd4;
    localparam logic [2:0] CLS_DROP = 3'd5;

    localparam logic [1:0] OKIND_NUM  = 2'd0;
    localparam logic [1:0] OKIND_FUNC = 2'd1;
    localparam logic [1:0] OKIND_OP   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PAREN = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic [2:0]  cls;
        logic [1:0]  op;
        logic [15:0] payload;
    } t_ent;

    typedef struct packed {
        t_ent ent;
        logic last;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [2:0] f_classify(input logic [2:0] kind);
        logic [2:0] cls;
        case (kind)
            KIND_NUM:  cls = CLS_NUM;
            KIND_FUNC: cls = CLS_FUNC;
            KIND_OP:   cls = CLS_OP;
            KIND_LPAR: cls = CLS_LPAR;
            KIND_RPAR: cls = CLS_RPAR;
            default:   cls = CLS_DROP;
        endcase
        return cls;
    endfunction

    function automatic logic [1:0] f_out_kind(input logic [2:0] cls);
        logic [1:0] k;
        case (cls)
            CLS_FUNC: k = OKIND_FUNC;
            CLS_OP:   k = OKIND_OP;
            default:  k = OKIND_NUM;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/infix_to_prefix_converter.sv */
`default_nettype none
// Top level of the infix to prefix converter: input stage, token queue and
// conversion engine. Depends on i2p_pkg, i2p_front, i2p_queue and i2p_back.
//
//   Channel   Direction  Handshake                   Payload
//   in        receive    i_in_valid / o_in_stall     token_kind, op_code, payload, last
//   out       send       o_out_valid / i_out_stall   out_kind, out_op, out_payload,
//                                                    status, end_of_run
//
// Tokens are stored at one per cycle while the engine is loading and tokens are queued.
// After the last token the engine reads and then handles each stored token; operators and
// matched parentheses come off the stack through a pop state, the scan closes in a flush
// state and each result goes out through an emit and an output state. The input keeps
// taking tokens into the queue until it is full. Reset is synchronous, active low and
// clears all control state. A stalled output holds the engine.

module infix_to_prefix_converter
    import i2p_pkg::*;
#(
    parameter int MAX_TOKENS = P_MAX_TOKENS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_token_kind,
    input  wire logic [1:0]  i_op_code,
    input  wire logic [15:0] i_payload,
    input  wire logic        i_last,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [1:0]  o_out_kind,
    output      logic [1:0]  o_out_op,
    output      logic [15:0] o_out_payload,
    output      logic [1:0]  o_status,
    output      logic        o_end_of_run
);

    logic   push;
    t_qent  push_data;
    logic   pop;
    t_qent  head;
    t_qstat qstat;

    i2p_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_token_kind (i_token_kind),
        .i_op_code    (i_op_code),
        .i_payload    (i_payload),
        .i_last       (i_last),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    i2p_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_qstat     (qstat)
    );

    i2p_back #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_op      (o_out_op),
        .o_out_payload (o_out_payload),
        .o_status      (o_status),
        .o_end_of_run  (o_end_of_run)
    );

endmodule

`default_nettype wire

/* hw/rtl/i2p_front.sv */
`default_nettype none
// Input stage: takes token transfers, classifies the token kind and holds
// the classified token until the queue takes it. Uses i2p_pkg.

module i2p_front
    import i2p_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_token_kind,
    input  wire logic [1:0]  i_op_code,
    input  wire logic [15:0] i_payload,
    input  wire logic        i_last,
    input  wire t_qstat      i_qstat,
    output      logic        o_push,
    output      t_qent       o_push_data
);

    logic  r_valid;
    t_qent r_data;
    logic  n_valid;
    logic  take;

    assign o_in_stall  = r_valid && i_qstat.full;
    assign o_push      = r_valid && !i_qstat.full;
    assign o_push_data = r_data;
    assign take        = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data.ent.cls     <= f_classify(i_token_kind);
            r_data.ent.op      <= i_op_code;
            r_data.ent.payload <= i_payload;
            r_data.last        <= i_last;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/i2p_queue.sv */
`default_nettype none
// Short queue between the input stage and the conversion engine.
// Uses i2p_pkg for the entry type and depth.

module i2p_queue
    import i2p_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qent  i_push_data,
    input  wire logic   i_pop,
    output      t_qent  o_head,
    output      t_qstat o_qstat
);

    t_qent            r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QAW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/i2p_back.sv */
`default_nettype none
// Conversion engine: stores the tokens of one expression, scans them in
// reverse with an operator stack, and sends out the prefix result or an error status. Uses i2p_pkg.

module i2p_back
    import i2p_pkg::*;
#(
    parameter int MAX_TOKENS = P_MAX_TOKENS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_qent       i_head,
    input  wire t_qstat      i_qstat,
    output      logic        o_pop,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [1:0]  o_out_kind,
    output      logic [1:0]  o_out_op,
    output      logic [15:0] o_out_payload,
    output      logic [1:0]  o_status,
    output      logic        o_end_of_run
);

    localparam int AW = $clog2(MAX_TOKENS);
    localparam int CW = $clog2(MAX_TOKENS + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_TOK   = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_ERR   = 3'd7;

    t_ent r_tok_mem [MAX_TOKENS];
    t_ent r_stk_mem [MAX_TOKENS];
    t_ent r_pre_mem [MAX_TOKENS];

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_ret, n_ret;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_n, n_n;
    logic [1:0]    r_err, n_err;
    t_ent          r_tos, n_tos;
    t_ent          r_cur;
    t_ent          r_stk_rd;
    t_ent          r_pre_rd;

    logic          tok_we, tok_re, stk_we, stk_re, pre_we, pre_re;
    t_ent          stk_wd, pre_wd;
    logic          out_free, out_ld;
    logic [1:0]    out_kind, out_op, out_status;
    logic [15:0]   out_payload;
    logic          out_end;
    logic          full_now;
    logic          tos_wins;

    assign out_free = !o_out_valid || !i_out_stall;
    assign full_now = (r_count == CW'(MAX_TOKENS));
    assign tos_wins = (r_sp != '0) && (r_tos.cls == CLS_OP) && r_tos.op[1] && !r_cur.op[1];

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_sp    = r_sp;
        n_n     = r_n;
        n_err   = r_err;
        n_tos   = r_tos;
        o_pop   = 1'b0;
        tok_we  = 1'b0;
        tok_re  = 1'b0;
        stk_we  = 1'b0;
        stk_re  = 1'b0;
        pre_we  = 1'b0;
        pre_re  = 1'b0;
        stk_wd  = r_cur;
        pre_wd  = r_cur;
        out_ld      = 1'b0;
        out_kind    = OKIND_NUM;
        out_op      = 2'd0;
        out_payload = 16'd0;
        out_status  = ST_OK;
        out_end     = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    if (full_now) begin
                        n_ovf = 1'b1;
                    end else begin
                        tok_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (i_head.last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_sp    = '0;
                        n_n     = '0;
                        n_idx   = full_now ? r_count : r_count + 1'b1;
                        if (r_ovf || full_now) begin
                            n_err   = ST_OVF;
                            n_state = S_ERR;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                if (r_idx == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    tok_re  = 1'b1;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_TOK;
                end
            end
            S_TOK: begin
                case (r_cur.cls)
                    CLS_NUM, CLS_FUNC: begin
                        pre_we  = 1'b1;
                        n_n     = r_n + 1'b1;
                        n_state = S_RD;
                    end
                    CLS_RPAR: begin
                        stk_we  = 1'b1;
                        n_tos   = r_cur;
                        n_sp    = r_sp + 1'b1;
                        n_state = S_RD;
                    end
                    CLS_LPAR: begin
                        if (r_sp == '0) begin
                            n_err   = ST_PAREN;
                            n_state = S_ERR;
                        end else if (r_tos.cls == CLS_RPAR) begin
                            stk_re  = 1'b1;
                            n_sp    = r_sp - 1'b1;
                            n_ret   = S_RD;
                            n_state = S_POP;
                        end else begin
                            pre_we  = 1'b1;
                            pre_wd  = r_tos;
                            n_n     = r_n + 1'b1;
                            stk_re  = 1'b1;
                            n_sp    = r_sp - 1'b1;
                            n_ret   = S_TOK;
                            n_state = S_POP;
                        end
                    end
                    CLS_OP: begin
                        if (tos_wins) begin
                            pre_we  = 1'b1;
                            pre_wd  = r_tos;
                            n_n     = r_n + 1'b1;
                            stk_re  = 1'b1;
                            n_sp    = r_sp - 1'b1;
                            n_ret   = S_TOK;
                            n_state = S_POP;
                        end else begin
                            stk_we  = 1'b1;
                            n_tos   = r_cur;
                            n_sp    = r_sp + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_RD;
                    end
                endcase
            end
            S_POP: begin
                n_tos   = r_stk_rd;
                n_state = r_ret;
            end
            S_FLUSH: begin
                if (r_sp == '0) begin
                    n_state = (r_n == '0) ? S_LOAD : S_EMIT;
                end else if (r_tos.cls == CLS_RPAR) begin
                    n_err   = ST_PAREN;
                    n_state = S_ERR;
                end else begin
                    pre_we  = 1'b1;
                    pre_wd  = r_tos;
                    n_n     = r_n + 1'b1;
                    stk_re  = 1'b1;
                    n_sp    = r_sp - 1'b1;
                    n_ret   = S_FLUSH;
                    n_state = S_POP;
                end
            end
            S_EMIT: begin
                pre_re  = 1'b1;
                n_n     = r_n - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_ld      = 1'b1;
                    out_kind    = f_out_kind(r_pre_rd.cls);
                    out_op      = (r_pre_rd.cls == CLS_OP) ? r_pre_rd.op : 2'd0;
                    out_payload = r_pre_rd.payload;
                    out_end     = (r_n == '0);
                    n_state     = (r_n == '0) ? S_LOAD : S_EMIT;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    out_status = r_err;
                    out_end    = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ret       <= S_RD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_sp        <= '0;
            r_n         <= '0;
            r_err       <= ST_OK;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_sp    <= n_sp;
            r_n     <= n_n;
            r_err   <= n_err;
            if (out_ld) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (out_ld) begin
            o_out_kind    <= out_kind;
            o_out_op      <= out_op;
            o_out_payload <= out_payload;
            o_status      <= out_status;
            o_end_of_run  <= out_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_we) begin
            r_tok_mem[r_count[AW-1:0]] <= i_head.ent;
        end
        if (tok_re) begin
            r_cur <= r_tok_mem[n_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[r_sp[AW-1:0]] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk_mem[AW'(r_sp - CW'(2))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_we) begin
            r_pre_mem[r_n[AW-1:0]] <= pre_wd;
        end
        if (pre_re) begin
            r_pre_rd <= r_pre_mem[n_n[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

/* tb/infix_to_prefix_converter_checker.sv */
`timescale 1ns / 1ps
// Checker for the infix to prefix converter: watches both channels, predicts the
// prefix stream of each expression and compares every result transfer with it.
// Depends on i2p_pkg for token kinds, result kinds, status codes and the store size.

module infix_to_prefix_converter_checker
    import i2p_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_token_kind,
    input  wire logic [1:0]  i_op_code,
    input  wire logic [15:0] i_payload,
    input  wire logic        i_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_out_kind,
    input  wire logic [1:0]  i_out_op,
    input  wire logic [15:0] i_out_payload,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_end_of_run,
    output int               o_fail_count,
    output int               o_due_count,
    output int               o_result_count,
    output int               o_error_count
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  op;
        logic [15:0] payload;
    } infix_tok_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  op;
        logic [15:0] payload;
        logic [1:0]  status;
        logic        run_end;
    } prefix_res_t;

    infix_tok_t  infix_tokens[$];
    prefix_res_t prefix_due[$];
    logic        token_overflow = 1'b0;
    int          fail_count     = 0;
    int          result_count   = 0;
    int          error_count    = 0;

    function automatic int op_rank(input infix_tok_t t);
        if (t.kind != KIND_OP) begin
            return 0;
        end
        return t.op[1] ? 2 : 1;
    endfunction

    // Right-to-left scan with an operator stack; the collected list is the
    // prefix stream backwards.
    task automatic convert_to_prefix();
        infix_tok_t  stack_q[$];
        infix_tok_t  rev_q[$];
        infix_tok_t  t;
        prefix_res_t r;
        logic        paren_bad;
        int          i;
        paren_bad = 1'b0;
        i = infix_tokens.size() - 1;
        while (i >= 0 && !paren_bad) begin
            t = infix_tokens[i];
            case (t.kind)
                KIND_NUM, KIND_FUNC: begin
                    rev_q.push_back(t);
                end
                KIND_RPAR: begin
                    stack_q.push_back(t);
                end
                KIND_LPAR: begin
                    while (stack_q.size() > 0 &&
                           stack_q[stack_q.size() - 1].kind != KIND_RPAR) begin
                        rev_q.push_back(stack_q.pop_back());
                    end
                    if (stack_q.size() == 0) begin
                        paren_bad = 1'b1;
                    end else begin
                        stack_q.delete(stack_q.size() - 1);
                    end
                end
                KIND_OP: begin
                    while (stack_q.size() > 0 &&
                           op_rank(stack_q[stack_q.size() - 1]) > op_rank(t)) begin
                        rev_q.push_back(stack_q.pop_back());
                    end
                    stack_q.push_back(t);
                end
                default: begin
                end
            endcase
            i--;
        end
        while (!paren_bad && stack_q.size() > 0) begin
            t = stack_q.pop_back();
            if (t.kind == KIND_RPAR) begin
                paren_bad = 1'b1;
            end else begin
                rev_q.push_back(t);
            end
        end

        r = '0;
        if (token_overflow) begin
            r.status  = ST_OVF;
            r.run_end = 1'b1;
            prefix_due.push_back(r);
        end else if (paren_bad) begin
            r.status  = ST_PAREN;
            r.run_end = 1'b1;
            prefix_due.push_back(r);
        end else begin
            for (i = rev_q.size() - 1; i >= 0; i--) begin
                t         = rev_q[i];
                r.kind    = (t.kind == KIND_OP) ? OKIND_OP :
                            (t.kind == KIND_FUNC) ? OKIND_FUNC : OKIND_NUM;
                r.op      = (t.kind == KIND_OP) ? t.op : 2'd0;
                r.payload = t.payload;
                r.status  = ST_OK;
                r.run_end = (i == 0);
                prefix_due.push_back(r);
            end
        end
    endtask

    task automatic take_token();
        infix_tok_t t;
        t.kind    = i_token_kind;
        t.op      = i_op_code;
        t.payload = i_payload;
        if (infix_tokens.size() < P_MAX_TOKENS) begin
            infix_tokens.push_back(t);
        end else begin
            token_overflow = 1'b1;
        end
        if (i_last) begin
            convert_to_prefix();
            infix_tokens.delete();
            token_overflow = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        prefix_res_t r;
        result_count++;
        if (prefix_due.size() == 0) begin
            fail_count++;
            $display("%0t ns: result transfer with nothing expected, actual kind %0h payload %0h",
                     $time, i_out_kind, i_out_payload);
        end else begin
            r = prefix_due.pop_front();
            if (r.status != ST_OK) begin
                error_count++;
            end
            check_field("out_kind", 16'(r.kind), 16'(i_out_kind));
            check_field("out_op", 16'(r.op), 16'(i_out_op));
            check_field("out_payload", r.payload, i_out_payload);
            check_field("status", 16'(r.status), 16'(i_status));
            check_field("end_of_run", 16'(r.run_end), 16'(i_end_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                take_token();
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_fail_count   <= fail_count;
        o_due_count    <= prefix_due.size();
        o_result_count <= result_count;
        o_error_count  <= error_count;
    end

endmodule

/* tb/infix_to_prefix_converter_tb.sv */
`timescale 1ns / 1ps
// Top of the infix to prefix converter testbench: clock, reset, token stimulus
// with bursts and gaps, output stall patterns and the final verdict.
// Depends on i2p_pkg, the converter RTL and infix_to_prefix_converter_checker.

module infix_to_prefix_converter_tb;
    import i2p_pkg::*;

    localparam logic [2:0] KIND_COMMA   = 3'd5;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam logic [1:0] OP_PLUS      = 2'd0;
    localparam logic [1:0] OP_MINUS     = 2'd1;
    localparam logic [1:0] OP_TIMES     = 2'd2;
    localparam logic [1:0] OP_DIVIDE    = 2'd3;

    localparam int RANDOM_TOKENS = 330;
    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = 500;
    localparam int LIMIT_CYCLES  = 200000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  op;
        logic [15:0] payload;
    } tok_t;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_token_kind;
    logic [1:0]  i_op_code;
    logic [15:0] i_payload;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_out_kind;
    logic [1:0]  o_out_op;
    logic [15:0] o_out_payload;
    logic [1:0]  o_status;
    logic        o_end_of_run;

    int   fail_count;
    int   due_count;
    int   result_count;
    int   error_count;
    int   cycle_count = 0;
    int   tokens_sent = 0;
    int   expr_sent   = 0;
    int   burst_left  = 0;
    logic steady      = 1'b0;
    logic hold_req;
    tok_t expr_q[$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    infix_to_prefix_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_token_kind  (i_token_kind),
        .i_op_code     (i_op_code),
        .i_payload     (i_payload),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_op      (o_out_op),
        .o_out_payload (o_out_payload),
        .o_status      (o_status),
        .o_end_of_run  (o_end_of_run)
    );

    infix_to_prefix_converter_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_token_kind   (i_token_kind),
        .i_op_code      (i_op_code),
        .i_payload      (i_payload),
        .i_last         (i_last),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_kind     (o_out_kind),
        .i_out_op       (o_out_op),
        .i_out_payload  (o_out_payload),
        .i_status       (o_status),
        .i_end_of_run   (o_end_of_run),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count),
        .o_result_count (result_count),
        .o_error_count  (error_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] any16();
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] any_op();
        return 2'($urandom_range(0, 3));
    endfunction

    task automatic add_tok(input logic [2:0] kind, input logic [1:0] op,
                           input logic [15:0] payload);
        tok_t t;
        t.kind    = kind;
        t.op      = op;
        t.payload = payload;
        expr_q.push_back(t);
    endtask

    task automatic add_chain(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (i > 0) begin
                add_tok(KIND_OP, any_op(), any16());
            end
            add_tok(KIND_NUM, any_op(), any16());
        end
    endtask

    task automatic gen_expr(input int depth);
        int terms;
        int i;
        terms = $urandom_range(1, 3);
        for (i = 0; i < terms; i++) begin
            if (i > 0) begin
                add_tok(KIND_OP, any_op(), any16());
            end
            gen_term(depth);
        end
    endtask

    task automatic gen_term(input int depth);
        int pick;
        int args;
        int j;
        pick = $urandom_range(0, 9);
        if (depth >= 3 || expr_q.size() > 40 || pick < 5) begin
            add_tok(KIND_NUM, any_op(), any16());
        end else if (pick < 7) begin
            add_tok(KIND_FUNC, any_op(), any16());
            add_tok(KIND_LPAR, any_op(), any16());
            args = $urandom_range(1, 3);
            for (j = 0; j < args; j++) begin
                if (j > 0) begin
                    add_tok(KIND_COMMA, any_op(), any16());
                end
                gen_expr(depth + 1);
            end
            add_tok(KIND_RPAR, any_op(), any16());
        end else begin
            add_tok(KIND_LPAR, any_op(), any16());
            gen_expr(depth + 1);
            add_tok(KIND_RPAR, any_op(), any16());
        end
    endtask

    task automatic break_expr();
        int   at;
        tok_t t;
        at = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 2))
            0: begin
                if (expr_q.size() > 1) begin
                    expr_q.delete(at);
                end
            end
            1: begin
                t.kind    = $urandom_range(0, 1) ? KIND_LPAR : KIND_RPAR;
                t.op      = any_op();
                t.payload = any16();
                expr_q.insert(at, t);
            end
            default: begin
                t = expr_q[at];
                t.kind = 3'($urandom_range(0, 7));
                expr_q[at] = t;
            end
        endcase
    endtask

    // Sends the queued expression; bursts and gaps run across expressions.
    task automatic send_expression();
        int k;
        int gap;
        steady = ($urandom_range(0, 4) == 0);
        for (k = 0; k < expr_q.size(); k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            i_in_valid   <= 1'b1;
            i_token_kind <= expr_q[k].kind;
            i_op_code    <= expr_q[k].op;
            i_payload    <= expr_q[k].payload;
            i_last       <= (k == expr_q.size() - 1);
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            tokens_sent++;
        end
        expr_sent++;
        expr_q.delete();
    endtask

    // Output side: random stall patterns, plus one long hold-off that lets
    // the block fill up while tokens keep coming.
    initial begin
        stall_mode_t mode;
        int          span;
        logic        hold_done;
        i_out_stall <= 1'b0;
        mode      = STALL_NONE;
        span      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ((span % 8) >= 5);
                endcase
            end
        end
    end

    initial begin
        int e;
        int pick;
        int first_random;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_token_kind <= KIND_NUM;
        i_op_code    <= OP_PLUS;
        i_payload    <= 16'h0000;
        i_last       <= 1'b0;
        hold_req     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lone number with all payload bits set; its operator field is ignored.
        add_tok(KIND_NUM, OP_DIVIDE, 16'hFFFF);
        send_expression();

        // Minus chain: left associativity.
        add_tok(KIND_NUM, OP_PLUS, 16'h0000);
        add_tok(KIND_OP, OP_MINUS, 16'h0001);
        add_tok(KIND_NUM, OP_PLUS, 16'h0002);
        add_tok(KIND_OP, OP_MINUS, 16'h0003);
        add_tok(KIND_NUM, OP_PLUS, 16'h0004);
        send_expression();

        // Mixed priorities.
        add_tok(KIND_NUM, OP_PLUS, 16'h0010);
        add_tok(KIND_OP, OP_TIMES, 16'h0011);
        add_tok(KIND_NUM, OP_PLUS, 16'h0012);
        add_tok(KIND_OP, OP_PLUS, 16'h0013);
        add_tok(KIND_NUM, OP_PLUS, 16'h0014);
        add_tok(KIND_OP, OP_DIVIDE, 16'h0015);
        add_tok(KIND_NUM, OP_PLUS, 16'h8000);
        send_expression();

        // Function call with two arguments.
        add_tok(KIND_FUNC, OP_TIMES, 16'hABCD);
        add_tok(KIND_LPAR, OP_PLUS, 16'h0000);
        add_tok(KIND_NUM, OP_PLUS, 16'h0020);
        add_tok(KIND_COMMA, OP_PLUS, 16'h0000);
        add_tok(KIND_NUM, OP_PLUS, 16'h0021);
        add_tok(KIND_RPAR, OP_PLUS, 16'h0000);
        send_expression();

        // Empty parentheses give no result at all.
        add_tok(KIND_LPAR, OP_PLUS, 16'h0000);
        add_tok(KIND_RPAR, OP_PLUS, 16'h0000);
        send_expression();

        // Left parenthesis without a partner.
        add_tok(KIND_LPAR, OP_PLUS, 16'h0000);
        add_tok(KIND_NUM, OP_PLUS, 16'h0030);
        send_expression();

        // Right parenthesis left on the stack.
        add_tok(KIND_NUM, OP_PLUS, 16'h0031);
        add_tok(KIND_RPAR, OP_PLUS, 16'h0000);
        send_expression();

        // Unknown kinds are dropped, including on the closing token.
        add_tok(KIND_NUM, OP_PLUS, 16'h0040);
        add_tok(KIND_SPARE_A, OP_TIMES, 16'h1234);
        add_tok(KIND_SPARE_B, OP_DIVIDE, 16'hFFFF);
        send_expression();

        hold_req <= 1'b1;
        first_random = tokens_sent;
        e = 0;
        while (tokens_sent - first_random < RANDOM_TOKENS) begin
            if (e == 3) begin
                // One token more than the store holds.
                add_chain(33);
            end else if (e == 7) begin
                // Exactly a full store.
                add_tok(KIND_COMMA, any_op(), any16());
                add_chain(32);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 17) begin
                    gen_expr(0);
                    if (pick >= 15) begin
                        break_expr();
                    end
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        add_tok(3'($urandom_range(0, 7)), any_op(), any16());
                    end
                end
            end
            send_expression();
            e++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d tokens in %0d expressions; %0d results checked, %0d with error.",
                 tokens_sent, expr_sent, result_count, error_count);
        $display("Covered all operators, functions, nesting, bad parentheses, %s",
                 "store overflow and a long output hold-off.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
